// ===== hw/rtl/ssgh_pkg.sv =====
// Shared types, constants and output saturation for the spring gradient/Hessian core.
package ssgh_pkg;

  localparam int MAG_W = 32;
  localparam int OUT_W = 48;
  localparam int SAT_W = 192;
  localparam int NPAIR = 6;

  // Unique Hessian entries in output order: xx, xy, xz, yy, yz, zz
  localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

  // Per-edge data carried alongside the arithmetic
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  deg;
  } ssgh_side_t;

  // Clamp a magnitude with sign to signed 48 bits
  function automatic logic [OUT_W-1:0] sat_out(input logic [SAT_W-1:0] m, input logic neg);
    logic             big;
    logic [OUT_W-1:0] r;
    if (!neg) begin
      big = |m[SAT_W-1:OUT_W-1];
      r   = big ? {1'b0, {(OUT_W-1){1'b1}}} : m[OUT_W-1:0];
    end else begin
      big = (|m[SAT_W-1:OUT_W]) || (m[OUT_W-1] && (|m[OUT_W-2:0]));
      r   = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~m[OUT_W-1:0]) + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ssgh_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module ssgh_sqrt #(
  parameter int RW = 49
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);
  localparam int XW = 2 * RW;

  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [XW-1:0] xs_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+1:0] rem_in;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic [RW-1:0] root_in;
    logic [XW-1:0] xs_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign xs_in   = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign xs_in   = xs_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_in[RW-1:0], xs_in[XW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
      root_r[k] <= {root_in[RW-2:0], ge};
      xs_r[k]   <= xs_in << 2;
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== hw/rtl/ssgh_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module ssgh_div #(
  parameter int NW = 96,
  parameter int DW = 66,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   r_sh;
    logic [DW:0]   r_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num >> QW);
      assign lo_in  = num[QW-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign den_in = den_r[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign r_sh  = {rem_in, lo_in[QW-1]};
    assign r_sub = r_sh - {1'b0, den_in};
    assign ge    = r_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
      lo_r[k]  <= {lo_in[QW-2:0], ge};
      den_r[k] <= den_in;
    end
  end

  assign quo = lo_r[QW-1];

endmodule

// ===== hw/rtl/spring_stretch_gradient_hessian_core.sv =====
// Spring stretch gradient and Hessian block: top level pipeline.
// One spring edge is accepted in every clock cycle (busy stays low) and its
// result appears on the out_ ports for one cycle, marked by out_valid, after
// three input stages, 33+F square-root stages, 96-F stages of the rest-length
// divider, and five stages for the spring factor, the split multiplies and
// saturation. The square root and the divider resolve one bit per stage. The
// receiver cannot stall the block, so every result must be taken as strobed.
// The stiffness register may only be written while no edge is in flight.
module spring_stretch_gradient_hessian_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic [30:0]        in_rest_length,
  output logic               out_valid,
  output logic signed [47:0] out_grad_x,
  output logic signed [47:0] out_grad_y,
  output logic signed [47:0] out_grad_z,
  output logic signed [47:0] out_hess_xx,
  output logic signed [47:0] out_hess_xy,
  output logic signed [47:0] out_hess_xz,
  output logic signed [47:0] out_hess_yy,
  output logic signed [47:0] out_hess_yz,
  output logic signed [47:0] out_hess_zz,
  output logic               out_degenerate
);
  import ssgh_pkg::*;

  localparam int RW      = 33 + FRAC_BITS;       // root width
  localparam int XW      = 2 * RW;               // radicand width
  localparam int QA      = 96 - FRAC_BITS;       // rest-length quotient width
  localparam int QE      = 33;                   // direction quotient width
  localparam int NCH     = (QA + 31) / 32;       // 32-bit chunks of A and |B|
  localparam int AW      = NCH * 32;
  localparam int PA      = AW + 33;
  localparam int PB      = AW + 32;
  localparam int SW      = AW + 34;
  localparam int LAT_A   = 3 + RW + QA;
  localparam int DE      = RW + QA - QE;
  localparam int DS      = RW + QA;
  localparam int LAT_OUT = LAT_A + 5;
  localparam int HSH     = 64 - FRAC_BITS;

  // stiffness register
  logic [31:0] stiffness_r;
  logic [32:0] two_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r <= 32'd65536;
    end else if (cfg_we) begin
      stiffness_r <= cfg_wdata;
    end
  end

  assign two_k = {stiffness_r, 1'b0};

  // fully pipelined: never holds off a request
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits travel with the data
  logic [LAT_OUT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT_OUT-2:0], accept};
    end
  end

  assign out_valid = vld_r[LAT_OUT-1];

  // stage 1: coordinate differences as magnitude and sign
  logic signed [32:0] diff [3];
  logic [MAG_W-1:0]   mag1_r [3];
  logic [2:0]         neg1_r;
  logic [30:0]        rest1_r;

  assign diff[0] = 33'(in_first_x) - 33'(in_second_x);
  assign diff[1] = 33'(in_first_y) - 33'(in_second_y);
  assign diff[2] = 33'(in_first_z) - 33'(in_second_z);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= diff[i][32] ? MAG_W'(-diff[i]) : diff[i][MAG_W-1:0];
      neg1_r[i] <= diff[i][32];
    end
    rest1_r <= in_rest_length;
  end

  // stage 2: component products and 2*ks*l0
  logic [63:0]      p2_r [NPAIR];
  logic [63:0]      kl2_r;
  logic [MAG_W-1:0] mag2_r [3];
  logic [2:0]       neg2_r;

  always_ff @(posedge clk) begin
    for (int n = 0; n < NPAIR; n++) begin
      p2_r[n] <= 64'(mag1_r[PAIR_I[n]]) * 64'(mag1_r[PAIR_J[n]]);
    end
    kl2_r  <= 64'(two_k) * 64'(rest1_r);
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
  end

  // stage 3: squared length
  logic [65:0] s_sum;
  logic [65:0] s3_r;
  logic [63:0] p3_r [NPAIR];
  logic [63:0] kl3_r;
  ssgh_side_t  side3_r;

  assign s_sum = 66'(p2_r[0]) + 66'(p2_r[3]) + 66'(p2_r[5]);

  always_ff @(posedge clk) begin
    s3_r  <= s_sum;
    p3_r  <= p2_r;
    kl3_r <= kl2_r;
    for (int i = 0; i < 3; i++) begin
      side3_r.mag[i] <= mag2_r[i];
    end
    side3_r.neg <= neg2_r;
    side3_r.deg <= (s_sum == 66'd0);
  end

  // length in Q.F: sqrt(S * 2^2F)
  logic [RW-1:0] lq;

  ssgh_sqrt #(.RW(RW)) u_sqrt (
    .clk  (clk),
    .rad  (XW'(s3_r) << (2 * FRAC_BITS)),
    .root (lq)
  );

  // 2*ks*l0 waits for the root
  logic [63:0] kl_dl_r [RW];

  always_ff @(posedge clk) begin
    kl_dl_r[0] <= kl3_r;
    for (int i = 1; i < RW; i++) begin
      kl_dl_r[i] <= kl_dl_r[i-1];
    end
  end

  // A = 2*ks*l0 / L with 32 fraction bits
  logic [QA-1:0] a_q;

  ssgh_div #(.NW(96), .DW(RW), .QW(QA)) u_div_a (
    .clk (clk),
    .num ({kl_dl_r[RW-1], 32'd0}),
    .den (lq),
    .quo (a_q)
  );

  // direction terms e_ij = |Di*Dj| / S with 32 fraction bits
  logic [NPAIR-1:0][QE-1:0] e_q;

  for (genvar n = 0; n < NPAIR; n++) begin : g_edir
    ssgh_div #(.NW(96), .DW(66), .QW(QE)) u_div_e (
      .clk (clk),
      .num ({p3_r[n], 32'd0}),
      .den (s3_r),
      .quo (e_q[n])
    );
  end

  // align direction terms and edge data with A
  logic [NPAIR-1:0][QE-1:0] e_dl_r [DE];
  ssgh_side_t               side_dl_r [DS];

  always_ff @(posedge clk) begin
    e_dl_r[0]    <= e_q;
    side_dl_r[0] <= side3_r;
    for (int i = 1; i < DE; i++) begin
      e_dl_r[i] <= e_dl_r[i-1];
    end
    for (int i = 1; i < DS; i++) begin
      side_dl_r[i] <= side_dl_r[i-1];
    end
  end

  // stage B: B = 2*ks - A as magnitude and sign
  logic [QA-1:0]            k2;
  logic                     bneg;
  logic [QA-1:0]            bmag;
  logic [AW-1:0]            ab_r;
  logic [AW-1:0]            bmb_r;
  logic                     bnegb_r;
  logic [NPAIR-1:0][QE-1:0] eb_r;
  ssgh_side_t               sideb_r;

  assign k2   = QA'(two_k) << (32 - FRAC_BITS);
  assign bneg = a_q > k2;
  assign bmag = bneg ? a_q - k2 : k2 - a_q;

  always_ff @(posedge clk) begin
    ab_r    <= AW'(a_q);
    bmb_r   <= AW'(bmag);
    bnegb_r <= bneg;
    eb_r    <= e_dl_r[DE-1];
    sideb_r <= side_dl_r[DS-1];
  end

  // stage M1: 32-bit partial products
  logic [64:0]   ppa_r [NPAIR][NCH];
  logic [63:0]   ppb_r [3][NCH];
  logic [AW-1:0] bm1_r;
  logic          bneg1_r;
  ssgh_side_t    side_m1_r;

  always_ff @(posedge clk) begin
    for (int n = 0; n < NPAIR; n++) begin
      for (int c = 0; c < NCH; c++) begin
        ppa_r[n][c] <= 65'(ab_r[c*32 +: 32]) * 65'(eb_r[n]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < NCH; c++) begin
        ppb_r[i][c] <= 64'(bmb_r[c*32 +: 32]) * 64'(sideb_r.mag[i]);
      end
    end
    bm1_r     <= bmb_r;
    bneg1_r   <= bnegb_r;
    side_m1_r <= sideb_r;
  end

  // stage M2: assemble full products
  logic [PA-1:0] proda_nxt [NPAIR];
  logic [PB-1:0] prodb_nxt [3];
  logic [PA-1:0] proda_r [NPAIR];
  logic [PB-1:0] prodb_r [3];
  logic [AW-1:0] bm2_r;
  logic          bneg2_r;
  ssgh_side_t    side_m2_r;

  always_comb begin
    for (int n = 0; n < NPAIR; n++) begin
      proda_nxt[n] = '0;
      for (int c = 0; c < NCH; c++) begin
        proda_nxt[n] = proda_nxt[n] + (PA'(ppa_r[n][c]) << (32 * c));
      end
    end
    for (int i = 0; i < 3; i++) begin
      prodb_nxt[i] = '0;
      for (int c = 0; c < NCH; c++) begin
        prodb_nxt[i] = prodb_nxt[i] + (PB'(ppb_r[i][c]) << (32 * c));
      end
    end
  end

  always_ff @(posedge clk) begin
    proda_r   <= proda_nxt;
    prodb_r   <= prodb_nxt;
    bm2_r     <= bm1_r;
    bneg2_r   <= bneg1_r;
    side_m2_r <= side_m1_r;
  end

  // stage M3: diagonal adds the B term, off-diagonal passes through
  logic [SW-1:0] bsh;
  logic [SW-1:0] hv_nxt [NPAIR];
  logic [SW-1:0] hv_r [NPAIR];
  logic [PB-1:0] prodb3_r [3];
  logic          bneg3_r;
  ssgh_side_t    side_m3_r;

  assign bsh = SW'(bm2_r) << 32;

  always_comb begin
    for (int n = 0; n < NPAIR; n++) begin
      if (PAIR_I[n] == PAIR_J[n]) begin
        hv_nxt[n] = bneg2_r ? SW'(proda_r[n]) - bsh : SW'(proda_r[n]) + bsh;
      end else begin
        hv_nxt[n] = SW'(proda_r[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    hv_r      <= hv_nxt;
    prodb3_r  <= prodb_r;
    bneg3_r   <= bneg2_r;
    side_m3_r <= side_m2_r;
  end

  // stage M4: scale, sign, saturate; coincident endpoints give zeros
  logic [OUT_W-1:0] grad_nxt [3];
  logic [OUT_W-1:0] hess_nxt [NPAIR];
  logic [OUT_W-1:0] grad_r [3];
  logic [OUT_W-1:0] hess_r [NPAIR];
  logic             deg_r;

  always_comb begin
    logic [SW-1:0] habs;
    logic          hneg;
    for (int i = 0; i < 3; i++) begin
      grad_nxt[i] = sat_out(SAT_W'(prodb3_r[i] >> 32), bneg3_r ^ side_m3_r.neg[i]);
      if (side_m3_r.deg) begin
        grad_nxt[i] = '0;
      end
    end
    for (int n = 0; n < NPAIR; n++) begin
      habs = hv_r[n][SW-1] ? SW'(-hv_r[n]) : hv_r[n];
      if (PAIR_I[n] == PAIR_J[n]) begin
        hneg = hv_r[n][SW-1];
      end else begin
        hneg = side_m3_r.neg[PAIR_I[n]] ^ side_m3_r.neg[PAIR_J[n]];
      end
      hess_nxt[n] = sat_out(SAT_W'(habs >> HSH), hneg);
      if (side_m3_r.deg) begin
        hess_nxt[n] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grad_r <= grad_nxt;
    hess_r <= hess_nxt;
    deg_r  <= side_m3_r.deg;
  end

  assign out_grad_x     = grad_r[0];
  assign out_grad_y     = grad_r[1];
  assign out_grad_z     = grad_r[2];
  assign out_hess_xx    = hess_r[0];
  assign out_hess_xy    = hess_r[1];
  assign out_hess_xz    = hess_r[2];
  assign out_hess_yy    = hess_r[3];
  assign out_hess_yz    = hess_r[4];
  assign out_hess_zz    = hess_r[5];
  assign out_degenerate = deg_r;

  // every request yields a result marked by out_valid
  a_req_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT_OUT out_valid)
    else $error("request without result");

  // no result without a request
  a_result_has_req : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT_OUT))
    else $error("result without request");

  // a degenerate flag implies coincident endpoints of that request
  a_deg_source : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> $past(in_first_x == in_second_x &&
      in_first_y == in_second_y && in_first_z == in_second_z, LAT_OUT))
    else $error("degenerate flag without coincident endpoints");

  // degenerate results carry zeros
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_grad_x == 48'sd0 && out_grad_y == 48'sd0 &&
      out_grad_z == 48'sd0 && out_hess_xx == 48'sd0 && out_hess_xy == 48'sd0 &&
      out_hess_xz == 48'sd0 && out_hess_yy == 48'sd0 && out_hess_yz == 48'sd0 &&
      out_hess_zz == 48'sd0)
    else $error("degenerate result not zero");

endmodule
